### design/tlnf_pkg.sv
package tlnf_pkg;

  localparam int unsigned NumberDigitsDefault = 6;
  localparam int unsigned QueueDepthDefault   = 4;

  localparam logic [7:0] CharTab     = 8'd9;
  localparam logic [7:0] CharNewline = 8'd10;
  localparam logic [7:0] CharSpace   = 8'd32;
  localparam logic [7:0] CharDollar  = 8'd36;
  localparam logic [7:0] CharZero    = 8'd48;
  localparam logic [7:0] CharQuery   = 8'd63;
  localparam logic [7:0] CharUpperI  = 8'd73;
  localparam logic [7:0] CharCaret   = 8'd94;
  localparam logic [7:0] CharDelete  = 8'd127;
  localparam logic [7:0] CtrlOffset  = 8'd64;
  localparam logic [7:0] CtrlLimit   = 8'd32;

  typedef enum logic [2:0] {
    RegNumberAll      = 3'd0,
    RegNumberNonblank = 3'd1,
    RegSqueezeBlank   = 3'd2,
    RegShowEnds       = 3'd3,
    RegShowTabs       = 3'd4,
    RegShowNonprint   = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic number_all;
    logic number_nonblank;
    logic squeeze_blank;
    logic show_ends;
    logic show_tabs;
    logic show_nonprinting;
  } cfg_t;

  // one queued item: optional number prefix, then one or two body bytes
  typedef struct packed {
    logic       prefix;
    logic       two;
    logic [7:0] b0;
    logic [7:0] b1;
  } cmd_t;

endpackage

### design/tlnf_fifo.sv
module tlnf_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntWidth = $clog2(Depth + 1);
  localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(Depth - 1);
  localparam logic [CntWidth-1:0] FullCnt = CntWidth'(Depth);

  logic [Width-1:0]    mem_q [Depth];
  logic [PtrWidth-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrWidth-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntWidth-1:0] count_q, count_d;
  logic                do_push, do_pop;

  assign full_o  = (count_q == FullCnt);
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

### design/tlnf_front.sv
module tlnf_front #(
  parameter int unsigned NumberDigits = tlnf_pkg::NumberDigitsDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  tlnf_pkg::cfg_t            cfg_i,
  input  logic                      push_i,
  input  logic                      full_i,
  input  logic [7:0]                in_byte_i,
  input  logic                      file_start_i,
  output logic                      q_push_o,
  output tlnf_pkg::cmd_t            q_cmd_o,
  output logic [4*NumberDigits-1:0] q_digits_o,
  output logic [NumberDigits-1:0]   q_blank_o
);

  localparam int unsigned CountWidth = 4 * NumberDigits;

  logic [CountWidth-1:0]   count_q, count_d, count_eff, count_inc;
  logic [1:0]              run_q, run_d, run_eff, run_next;
  logic [NumberDigits:0]   all9;
  logic [NumberDigits:0]   zero_above;
  logic                    accept, is_nl, is_tab, squeezed, prefix;
  tlnf_pkg::cmd_t          cmd;

  assign accept = push_i && !full_i;

  always_comb begin
    count_eff = file_start_i ? CountWidth'(1) : count_q;
    run_eff   = file_start_i ? 2'd1 : run_q;
    is_nl     = (in_byte_i == tlnf_pkg::CharNewline);
    is_tab    = (in_byte_i == tlnf_pkg::CharTab);
    squeezed  = cfg_i.squeeze_blank && is_nl && (run_eff > 2'd1);
    if (cfg_i.number_nonblank) begin
      prefix = !is_nl && (run_eff != 2'd0);
    end else begin
      prefix = cfg_i.number_all && (run_eff != 2'd0);
    end

    // bcd increment, saturating at all nines
    all9[0] = 1'b1;
    for (int i = 0; i < NumberDigits; i++) begin
      all9[i+1] = all9[i] && (count_eff[4*i +: 4] == 4'd9);
    end
    for (int i = 0; i < NumberDigits; i++) begin
      if (all9[i] && !all9[NumberDigits]) begin
        count_inc[4*i +: 4] = (count_eff[4*i +: 4] == 4'd9) ? 4'd0
                                                             : count_eff[4*i +: 4] + 4'd1;
      end else begin
        count_inc[4*i +: 4] = count_eff[4*i +: 4];
      end
    end

    // leading zero suppression, lowest digit always shown
    zero_above[NumberDigits] = 1'b1;
    for (int i = NumberDigits - 1; i >= 0; i--) begin
      zero_above[i] = zero_above[i+1] && (count_eff[4*i +: 4] == 4'd0);
      q_blank_o[i]  = zero_above[i] && (i != 0);
    end

    if (!is_nl) begin
      run_next = 2'd0;
    end else if (run_eff == 2'd3) begin
      run_next = 2'd3;
    end else begin
      run_next = run_eff + 2'd1;
    end

    cmd.prefix = prefix;
    cmd.two    = 1'b1;
    cmd.b0     = tlnf_pkg::CharCaret;
    cmd.b1     = in_byte_i;
    priority if (cfg_i.show_ends && is_nl) begin
      cmd.b0 = tlnf_pkg::CharDollar;
      cmd.b1 = tlnf_pkg::CharNewline;
    end else if (cfg_i.show_tabs && is_tab) begin
      cmd.b1 = tlnf_pkg::CharUpperI;
    end else if (cfg_i.show_nonprinting && (in_byte_i < tlnf_pkg::CtrlLimit)
                 && !is_nl && !is_tab) begin
      cmd.b1 = in_byte_i + tlnf_pkg::CtrlOffset;
    end else if (cfg_i.show_nonprinting && (in_byte_i == tlnf_pkg::CharDelete)) begin
      cmd.b1 = tlnf_pkg::CharQuery;
    end else begin
      cmd.two = 1'b0;
      cmd.b0  = in_byte_i;
    end

    count_d = count_q;
    run_d   = run_q;
    if (accept) begin
      count_d = (!squeezed && prefix) ? count_inc : count_eff;
      run_d   = squeezed ? run_eff : run_next;
    end
  end

  assign q_push_o   = accept && !squeezed;
  assign q_cmd_o    = cmd;
  assign q_digits_o = count_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CountWidth'(1);
      run_q   <= 2'd1;
    end else begin
      count_q <= count_d;
      run_q   <= run_d;
    end
  end

endmodule

### design/tlnf_back.sv
module tlnf_back #(
  parameter int unsigned NumberDigits = tlnf_pkg::NumberDigitsDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      q_empty_i,
  input  tlnf_pkg::cmd_t            q_cmd_i,
  input  logic [4*NumberDigits-1:0] q_digits_i,
  input  logic [NumberDigits-1:0]   q_blank_i,
  output logic                      q_pop_o,
  output logic                      empty_o,
  input  logic                      pop_i,
  output logic [7:0]                out_byte_o,
  output logic                      last_o
);

  localparam int unsigned PosWidth = $clog2(NumberDigits + 3);
  localparam logic [PosWidth-1:0] TabPos   = PosWidth'(NumberDigits);
  localparam logic [PosWidth-1:0] Body0Pos = PosWidth'(NumberDigits + 1);
  localparam logic [PosWidth-1:0] Body1Pos = PosWidth'(NumberDigits + 2);

  logic [PosWidth-1:0] k_q, k_d, idx;
  logic                out_valid_q, out_valid_d;
  logic [7:0]          out_byte_q, emit_byte;
  logic                out_last_q, emit_last;
  logic                advance;

  assign advance = !q_empty_i && (!out_valid_q || pop_i);
  assign idx     = q_cmd_i.prefix ? k_q : k_q + Body0Pos;

  always_comb begin
    emit_byte = q_cmd_i.b1;
    for (int i = 0; i < NumberDigits; i++) begin
      if (idx == PosWidth'(NumberDigits - 1 - i)) begin
        emit_byte = q_blank_i[i] ? tlnf_pkg::CharSpace
                                 : tlnf_pkg::CharZero + {4'd0, q_digits_i[4*i +: 4]};
      end
    end
    if (idx == TabPos) begin
      emit_byte = tlnf_pkg::CharTab;
    end else if (idx == Body0Pos) begin
      emit_byte = q_cmd_i.b0;
    end
    emit_last = ((idx == Body0Pos) && !q_cmd_i.two) || (idx == Body1Pos);

    k_d         = k_q;
    out_valid_d = out_valid_q;
    if (advance) begin
      k_d         = emit_last ? '0 : k_q + 1'b1;
      out_valid_d = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign q_pop_o    = advance && emit_last;
  assign empty_o    = !out_valid_q;
  assign out_byte_o = out_byte_q;
  assign last_o     = out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_byte_q <= emit_byte;
      out_last_q <= emit_last;
    end
  end

  a_step_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !emit_last) |=> (k_q == $past(k_q) + 1'b1))
    else $error("byte position did not advance");

  a_step_wrap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && emit_last) |=> (k_q == '0))
    else $error("byte position not cleared after last byte");

  a_head_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (k_q != '0) |-> !q_empty_i)
    else $error("queue head lost in the middle of an item");

  a_last_pops : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!q_empty_i && !q_pop_o && (!out_valid_q || pop_i)) |=> !out_last_q)
    else $error("last byte sent without popping the queue");

endmodule

### design/text_line_number_filter.sv
// text_line_number_filter: line numbering filter for a byte stream
//
// input queue side: present in_byte_i and file_start_i with push; the item is
// taken on a clock edge with push high and full low. file_start_i clears the
// line counter and blank-line run before its byte is handled.
// result queue side: while empty is low, out_byte_o/last_o hold the oldest
// output byte; pop takes it. last_o marks the final byte of one input item.
// a squeezed newline gives no output bytes at all.
// config side: cfg_index_i/cfg_data_i written when cfg_valid_i is high;
// cfg_ready_o is always high. write only while the block is idle.
// an item's first output byte passes the command queue, then the output register.
// the front end takes one item per cycle into a short command queue while full is
// low; the back end sends one output byte per cycle while the receiver pops, so an
// item gives one byte, two for an escaped byte, and NumberDigits+2 or +3 with a
// prefix. when the receiver stalls, the output register holds and the queue fills;
// full rises once the command queue is full. reset sets the config to zero, the
// line counter and blank-line run to one and the queue and output to empty.
module text_line_number_filter #(
  parameter int unsigned NumberDigits = tlnf_pkg::NumberDigitsDefault,
  parameter int unsigned QueueDepth   = tlnf_pkg::QueueDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte_i,
  input  logic       file_start_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_o,
  output logic       last_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [2:0] cfg_index_i,
  input  logic       cfg_data_i
);

  localparam int unsigned CmdWidth   = $bits(tlnf_pkg::cmd_t);
  localparam int unsigned EntryWidth = CmdWidth + 5 * NumberDigits;

  tlnf_pkg::cfg_t            cfg_q, cfg_d;
  tlnf_pkg::cmd_t            f_cmd, b_cmd;
  logic [4*NumberDigits-1:0] f_digits, b_digits;
  logic [NumberDigits-1:0]   f_blank, b_blank;
  logic [EntryWidth-1:0]     q_wdata, q_rdata;
  logic                      q_push, q_pop, q_empty;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (tlnf_pkg::cfg_reg_e'(cfg_index_i))
        tlnf_pkg::RegNumberAll:      cfg_d.number_all       = cfg_data_i;
        tlnf_pkg::RegNumberNonblank: cfg_d.number_nonblank  = cfg_data_i;
        tlnf_pkg::RegSqueezeBlank:   cfg_d.squeeze_blank    = cfg_data_i;
        tlnf_pkg::RegShowEnds:       cfg_d.show_ends        = cfg_data_i;
        tlnf_pkg::RegShowTabs:       cfg_d.show_tabs        = cfg_data_i;
        tlnf_pkg::RegShowNonprint:   cfg_d.show_nonprinting = cfg_data_i;
        default:                     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  tlnf_front #(
    .NumberDigits(NumberDigits)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .push_i      (push),
    .full_i      (full),
    .in_byte_i   (in_byte_i),
    .file_start_i(file_start_i),
    .q_push_o    (q_push),
    .q_cmd_o     (f_cmd),
    .q_digits_o  (f_digits),
    .q_blank_o   (f_blank)
  );

  assign q_wdata = {f_blank, f_digits, f_cmd};
  assign {b_blank, b_digits, b_cmd} = q_rdata;

  tlnf_fifo #(
    .Width(EntryWidth),
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .wdata_i(q_wdata),
    .full_o (full),
    .pop_i  (q_pop),
    .rdata_o(q_rdata),
    .empty_o(q_empty)
  );

  tlnf_back #(
    .NumberDigits(NumberDigits)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_cmd_i   (b_cmd),
    .q_digits_i(b_digits),
    .q_blank_i (b_blank),
    .q_pop_o   (q_pop),
    .empty_o   (empty),
    .pop_i     (pop),
    .out_byte_o(out_byte_o),
    .last_o    (last_o)
  );

endmodule

### tb/sv/text_line_number_filter_test.sv
module text_line_number_filter_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Digits = tlnf_pkg::NumberDigitsDefault;
  localparam int unsigned CountWidth = 4 * Digits;
  localparam int unsigned ItemsPerPhase = 64;
  localparam int unsigned NumPhases = 6;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned HoldCycles = 150;
  localparam logic [2:0] RegSpareLow = 3'd6;
  localparam logic [2:0] RegSpareHigh = 3'd7;

  // bit 8 is file_start, bits 7:0 the text byte
  localparam logic [8:0] DirectedItems [18] = '{
    {1'b1, 8'h41}, {1'b0, 8'h00}, {1'b0, 8'h1f}, {1'b0, tlnf_pkg::CharTab},
    {1'b0, tlnf_pkg::CharDelete}, {1'b0, 8'h80}, {1'b0, 8'hff}, {1'b0, 8'h7e},
    {1'b0, tlnf_pkg::CharNewline}, {1'b0, tlnf_pkg::CharNewline},
    {1'b0, tlnf_pkg::CharNewline}, {1'b0, tlnf_pkg::CharNewline},
    {1'b0, tlnf_pkg::CharSpace}, {1'b0, tlnf_pkg::CharNewline},
    {1'b1, tlnf_pkg::CharNewline}, {1'b0, tlnf_pkg::CharNewline},
    {1'b1, 8'h78}, {1'b0, tlnf_pkg::CharNewline}
  };

  // fields: number_all, number_nonblank, squeeze_blank, show_ends, show_tabs,
  // show_nonprinting
  localparam tlnf_pkg::cfg_t PhaseCfg [NumPhases-1] = '{
    tlnf_pkg::cfg_t'(6'b111111), tlnf_pkg::cfg_t'(6'b000000),
    tlnf_pkg::cfg_t'(6'b100100), tlnf_pkg::cfg_t'(6'b011010),
    tlnf_pkg::cfg_t'(6'b101001)
  };

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_byte_t;

  class numbered_text_model;
    logic [CountWidth-1:0] line_count;
    logic [1:0]            newline_run;
    tlnf_pkg::cfg_t        cfg;
    text_byte_t            expected_text [$];
    int unsigned           failures;

    function new();
      line_count = CountWidth'(1);
      newline_run = 2'd1;
      cfg = '0;
      failures = 0;
    endfunction

    function void set_reg(logic [2:0] index, logic value);
      case (index)
        tlnf_pkg::RegNumberAll:      cfg.number_all = value;
        tlnf_pkg::RegNumberNonblank: cfg.number_nonblank = value;
        tlnf_pkg::RegSqueezeBlank:   cfg.squeeze_blank = value;
        tlnf_pkg::RegShowEnds:       cfg.show_ends = value;
        tlnf_pkg::RegShowTabs:       cfg.show_tabs = value;
        tlnf_pkg::RegShowNonprint:   cfg.show_nonprinting = value;
        default: ;
      endcase
    endfunction

    function void bump_line_count();
      logic [3:0] d;
      logic       carry;
      if (line_count == {Digits{4'h9}}) return;
      carry = 1'b1;
      for (int i = 0; i < Digits; i++) begin
        d = line_count[4*i +: 4] + carry;
        carry = (d >= 4'd10);
        if (carry) d = d - 4'd10;
        line_count[4*i +: 4] = d;
      end
    endfunction

    function void add_input(logic [7:0] ch, logic start);
      logic [7:0] seq [$];
      logic       prefix;
      logic       leading;
      logic [3:0] d;
      text_byte_t entry;
      if (start) begin
        line_count = CountWidth'(1);
        newline_run = 2'd1;
      end
      if (cfg.squeeze_blank && ch == tlnf_pkg::CharNewline && newline_run > 2'd1) return;
      if (cfg.number_nonblank) begin
        prefix = (ch != tlnf_pkg::CharNewline) && (newline_run != 2'd0);
      end else begin
        prefix = cfg.number_all && (newline_run != 2'd0);
      end
      if (prefix) begin
        leading = 1'b1;
        for (int i = Digits - 1; i >= 0; i--) begin
          d = line_count[4*i +: 4];
          if (d != 4'd0 || i == 0) leading = 1'b0;
          seq.push_back(leading ? tlnf_pkg::CharSpace : tlnf_pkg::CharZero + 8'(d));
        end
        seq.push_back(tlnf_pkg::CharTab);
        bump_line_count();
      end
      if (ch == tlnf_pkg::CharNewline) begin
        if (newline_run != 2'd3) newline_run = newline_run + 2'd1;
      end else begin
        newline_run = 2'd0;
      end
      if (cfg.show_ends && ch == tlnf_pkg::CharNewline) begin
        seq.push_back(tlnf_pkg::CharDollar);
        seq.push_back(tlnf_pkg::CharNewline);
      end else if (cfg.show_tabs && ch == tlnf_pkg::CharTab) begin
        seq.push_back(tlnf_pkg::CharCaret);
        seq.push_back(tlnf_pkg::CharUpperI);
      end else if (cfg.show_nonprinting && ch < tlnf_pkg::CtrlLimit &&
                   ch != tlnf_pkg::CharNewline && ch != tlnf_pkg::CharTab) begin
        seq.push_back(tlnf_pkg::CharCaret);
        seq.push_back(ch + tlnf_pkg::CtrlOffset);
      end else if (cfg.show_nonprinting && ch == tlnf_pkg::CharDelete) begin
        seq.push_back(tlnf_pkg::CharCaret);
        seq.push_back(tlnf_pkg::CharQuery);
      end else begin
        seq.push_back(ch);
      end
      foreach (seq[i]) begin
        entry.ch = seq[i];
        entry.last = (i == seq.size() - 1);
        expected_text.push_back(entry);
      end
    endfunction

    function void check_output(logic [7:0] ch, logic last);
      text_byte_t want;
      if (expected_text.size() == 0) begin
        failures++;
        $display("%0t: unexpected output byte: expected none, actual %h last %b",
                 $time, ch, last);
        return;
      end
      want = expected_text.pop_front();
      if (ch !== want.ch) begin
        failures++;
        $display("%0t: out_byte mismatch: expected %h, actual %h", $time, want.ch, ch);
      end
      if (last !== want.last) begin
        failures++;
        $display("%0t: last mismatch: expected %b, actual %b", $time, want.last, last);
      end
    endfunction

    function int unsigned pending();
      return expected_text.size();
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       push;
  logic       full;
  logic [7:0] in_byte_i;
  logic       file_start_i;
  logic       empty;
  logic       pop;
  logic [7:0] out_byte_o;
  logic       last_o;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [2:0] cfg_index_i;
  logic       cfg_data_i;

  numbered_text_model model = new();
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          hold_request = 1'b0;

  text_line_number_filter dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .in_byte_i    (in_byte_i),
    .file_start_i (file_start_i),
    .empty        (empty),
    .pop          (pop),
    .out_byte_o   (out_byte_o),
    .last_o       (last_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  task automatic write_reg(logic [2:0] index, logic value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    model.set_reg(index, value);
  endtask

  task automatic apply_settings(tlnf_pkg::cfg_t c);
    write_reg(RegSpareLow, 1'($urandom_range(1)));
    write_reg(tlnf_pkg::RegNumberAll, c.number_all);
    write_reg(tlnf_pkg::RegNumberNonblank, c.number_nonblank);
    write_reg(tlnf_pkg::RegSqueezeBlank, c.squeeze_blank);
    write_reg(tlnf_pkg::RegShowEnds, c.show_ends);
    write_reg(tlnf_pkg::RegShowTabs, c.show_tabs);
    write_reg(tlnf_pkg::RegShowNonprint, c.show_nonprinting);
    write_reg(RegSpareHigh, 1'($urandom_range(1)));
    cfg_valid_i <= 1'b0;
  endtask

  // push stays high after acceptance; the caller's next step decides it
  task automatic send_text_byte(logic [7:0] ch, logic start);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    in_byte_i <= ch;
    file_start_i <= start;
    do @(posedge clk_i); while (full);
    model.add_input(ch, start);
  endtask

  task automatic settle_output();
    push <= 1'b0;
    while (model.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_text_byte();
    case ($urandom_range(9))
      0, 1, 2: return tlnf_pkg::CharNewline;
      3:       return tlnf_pkg::CharTab;
      4:       return 8'($urandom_range(31));
      5:       return tlnf_pkg::CharDelete;
      6:       return 8'($urandom_range(255, 128));
      7:       return 8'($urandom_range(255));
      default: return 8'($urandom_range(126, 32));
    endcase
  endfunction

  initial begin
    int unsigned hold_left;
    hold_left = 0;
    pop <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) model.check_output(out_byte_o, last_o);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        pop <= 1'b0;
        hold_left--;
      end else begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    tlnf_pkg::cfg_t cfg;
    rst_ni <= 1'b0;
    push <= 1'b0;
    in_byte_i <= '0;
    file_start_i <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 7;
    recv_idle_pct = 82;
    apply_settings(PhaseCfg[0]);
    foreach (DirectedItems[i]) send_text_byte(DirectedItems[i][7:0], DirectedItems[i][8]);

    for (int phase = 0; phase < NumPhases; phase++) begin
      settle_output();
      if (phase < 2) begin
        send_idle_pct = 7;
        recv_idle_pct = 82;
      end else if (phase < 4) begin
        send_idle_pct = 82;
        recv_idle_pct = 7;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      cfg = (phase < NumPhases - 1) ? PhaseCfg[phase]
                                    : tlnf_pkg::cfg_t'($urandom_range(63));
      apply_settings(cfg);
      if (phase == 4) hold_request = 1'b1;
      repeat (ItemsPerPhase) send_text_byte(pick_text_byte(), $urandom_range(99) < 3);
    end

    settle_output();
    if (model.failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

### text_line_number_filter.f
design/tlnf_pkg.sv
design/tlnf_fifo.sv
design/tlnf_front.sv
design/tlnf_back.sv
design/text_line_number_filter.sv
tb/sv/text_line_number_filter_test.sv
